/* rtl/ffsa_pkg.sv */
`default_nettype none
package ffsa_pkg;

	localparam int MaxSegments = 64;
	localparam int OffsetBits = 24;
	localparam int IdxBits = $clog2(MaxSegments);
	localparam int CntBits = $clog2(MaxSegments + 1);
	localparam logic [OffsetBits-1:0] DefaultHeap = OffsetBits'(10000000);
	localparam logic [23:0] DefaultWindow = 24'd1998;

	// result codes
	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StNoFit = 3'd1;
	localparam logic [2:0] StWindow = 3'd2;
	localparam logic [2:0] StNotFound = 3'd3;
	localparam logic [2:0] StFull = 3'd4;

	// register indexes
	localparam logic [1:0] RegHeap = 2'd0;
	localparam logic [1:0] RegWinEn = 2'd1;
	localparam logic [1:0] RegWinLo = 2'd2;
	localparam logic [1:0] RegWinHi = 2'd3;

	typedef struct packed {
		logic action;
		logic [23:0] request_size;
		logic [23:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [23:0] block_offset;
		logic [23:0] grant_size;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [OffsetBits-1:0] start;
		logic [OffsetBits-1:0] len;
		logic busy;
	} seg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SPLIT_WR,
		S_REL_NEXT,
		S_REL_PREV,
		S_DEL_RD,
		S_DEL_WR,
		S_DONE
	} fsm_t;

	// configuration snapshot handed to the engine
	typedef struct packed {
		logic init;
		logic [OffsetBits-1:0] heap;
		logic win_en;
		logic [23:0] win_min;
		logic [23:0] win_max;
	} cfg_t;

endpackage
`default_nettype wire

/* rtl/ffsa_regs.sv */
`default_nettype none
module ffsa_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output ffsa_pkg::cfg_t cfg
);

	logic [23:0] heap_q, lo_q, hi_q;
	logic en_q, init_q, wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= ffsa_pkg::DefaultHeap;
			en_q <= 1'b0;
			lo_q <= ffsa_pkg::DefaultWindow;
			hi_q <= ffsa_pkg::DefaultWindow;
			init_q <= 1'b0;
		end else begin
			init_q <= 1'b0;
			if (wr) begin
				unique case (idx)
					ffsa_pkg::RegHeap: begin
						heap_q <= pwdata[23:0];
						init_q <= 1'b1;
					end
					ffsa_pkg::RegWinEn: en_q <= pwdata[0];
					ffsa_pkg::RegWinLo: lo_q <= pwdata[23:0];
					ffsa_pkg::RegWinHi: hi_q <= pwdata[23:0];
					default: ;
				endcase
			end
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			ffsa_pkg::RegHeap: prdata = {8'd0, heap_q};
			ffsa_pkg::RegWinEn: prdata = {31'd0, en_q};
			ffsa_pkg::RegWinLo: prdata = {8'd0, lo_q};
			ffsa_pkg::RegWinHi: prdata = {8'd0, hi_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cfg.init = init_q;
		cfg.heap = (heap_q == 24'd0) ? ffsa_pkg::DefaultHeap : heap_q;
		cfg.win_en = en_q;
		cfg.win_min = (lo_q > hi_q) ? hi_q : lo_q;
		cfg.win_max = (lo_q > hi_q) ? lo_q : hi_q;
	end

endmodule
`default_nettype wire

/* rtl/ffsa_engine.sv */
`default_nettype none
module ffsa_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire ffsa_pkg::cfg_t cfg,
	input wire logic start,
	input wire ffsa_pkg::req_t req,
	output logic busy,
	output logic done,
	output ffsa_pkg::rsp_t result
);

	localparam int IB = ffsa_pkg::IdxBits;
	localparam int CB = ffsa_pkg::CntBits;
	localparam int OB = ffsa_pkg::OffsetBits;

	// segment table, one read and one write port
	ffsa_pkg::seg_t mem [ffsa_pkg::MaxSegments];
	logic [IB-1:0] raddr, waddr;
	logic wen;
	ffsa_pkg::seg_t wdata, rdata_s1;

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	// entry 0 after init reads as the full free heap until written
	logic e0_valid_q;
	logic [OB-1:0] heap_q;
	logic [IB-1:0] raddr_q;
	ffsa_pkg::seg_t rd;
	always_comb begin
		rd = rdata_s1;
		if (!e0_valid_q && raddr_q == '0) begin
			rd.start = '0;
			rd.len = heap_q;
			rd.busy = 1'b0;
		end
	end

	ffsa_pkg::fsm_t state_q, state_d;
	logic [CB-1:0] cnt_q, cnt_d;
	logic [CB-1:0] i_q, i_d, j_q, j_d;
	ffsa_pkg::req_t req_q;
	ffsa_pkg::seg_t cur_q, cur_d;
	ffsa_pkg::rsp_t res_q, res_d;
	logic done_q, done_d;

	assign busy = (state_q != ffsa_pkg::S_IDLE);
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_IDLE;
			cnt_q <= CB'(1);
			e0_valid_q <= 1'b0;
			heap_q <= ffsa_pkg::DefaultHeap;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			done_q <= done_d;
			if (cfg.init) begin
				cnt_q <= CB'(1);
				e0_valid_q <= 1'b0;
				heap_q <= cfg.heap;
			end else if (wen && waddr == '0) begin
				e0_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		cur_q <= cur_d;
		res_q <= res_d;
		raddr_q <= raddr;
		if (start && !busy) req_q <= req;
	end

	// sequencer: scan, then shift up to insert or shift down to delete
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		i_d = i_q;
		j_d = j_q;
		cur_d = cur_q;
		res_d = res_q;
		done_d = 1'b0;
		raddr = i_q[IB-1:0];
		wen = 1'b0;
		waddr = i_q[IB-1:0];
		wdata = cur_q;
		unique case (state_q)
			ffsa_pkg::S_IDLE: begin
				if (start) begin
					res_d = '0;
					i_d = '0;
					raddr = '0;
					state_d = ffsa_pkg::S_SCAN_WAIT;
					if (!req.action) begin
						if (cfg.win_en && (req.request_size < cfg.win_min ||
							req.request_size > cfg.win_max)) begin
							res_d.status = ffsa_pkg::StWindow;
							state_d = ffsa_pkg::S_DONE;
						end else if (req.request_size == '0) begin
							res_d.status = ffsa_pkg::StNoFit;
							state_d = ffsa_pkg::S_DONE;
						end
					end
				end
			end
			ffsa_pkg::S_SCAN: begin
				// issue read of entry i
				raddr = i_q[IB-1:0];
				state_d = ffsa_pkg::S_SCAN_WAIT;
			end
			ffsa_pkg::S_SCAN_WAIT: begin
				cur_d = rd;
				if (!req_q.action) begin
					if (!rd.busy && rd.len >= req_q.request_size) begin
						if (rd.len != req_q.request_size) begin
							if (cnt_q >= CB'(ffsa_pkg::MaxSegments)) begin
								res_d.status = ffsa_pkg::StFull;
								state_d = ffsa_pkg::S_DONE;
							end else begin
								// shift entries i+1..cnt-1 up, from the top
								j_d = cnt_q;
								state_d = ffsa_pkg::S_SHIFT_RD;
							end
						end else begin
							wen = 1'b1;
							wdata = rd;
							wdata.busy = 1'b1;
							res_d.status = ffsa_pkg::StOk;
							res_d.block_offset = rd.start;
							res_d.grant_size = req_q.request_size;
							state_d = ffsa_pkg::S_DONE;
						end
					end else if (i_q + CB'(1) >= cnt_q) begin
						res_d.status = ffsa_pkg::StNoFit;
						state_d = ffsa_pkg::S_DONE;
					end else begin
						i_d = i_q + CB'(1);
						raddr = i_d[IB-1:0];
					end
				end else begin
					if (rd.start == req_q.release_offset) begin
						res_d.status = ffsa_pkg::StOk;
						res_d.block_offset = rd.start;
						res_d.grant_size = rd.len;
						cur_d.busy = 1'b0;
						if (i_q + CB'(1) < cnt_q) begin
							raddr = IB'(i_q + CB'(1));
							state_d = ffsa_pkg::S_REL_NEXT;
						end else begin
							// last entry: no next merge
							wen = 1'b1;
							wdata = cur_d;
							j_d = '1;
							state_d = ffsa_pkg::S_REL_PREV;
							raddr = IB'(i_q - CB'(1));
						end
					end else if (i_q + CB'(1) >= cnt_q) begin
						res_d.status = ffsa_pkg::StNotFound;
						state_d = ffsa_pkg::S_DONE;
					end else begin
						i_d = i_q + CB'(1);
						raddr = i_d[IB-1:0];
					end
				end
			end
			ffsa_pkg::S_SHIFT_RD: begin
				if (j_q == i_q + CB'(1)) begin
					state_d = ffsa_pkg::S_SPLIT_WR;
				end else begin
					raddr = IB'(j_q - CB'(1));
					state_d = ffsa_pkg::S_SHIFT_WR;
				end
			end
			ffsa_pkg::S_SHIFT_WR: begin
				wen = 1'b1;
				waddr = j_q[IB-1:0];
				wdata = rd;
				j_d = j_q - CB'(1);
				state_d = ffsa_pkg::S_SHIFT_RD;
			end
			ffsa_pkg::S_SPLIT_WR: begin
				// write remainder at i+1 now, busy head at i next
				wen = 1'b1;
				waddr = IB'(i_q + CB'(1));
				wdata.start = cur_q.start + req_q.request_size;
				wdata.len = cur_q.len - req_q.request_size;
				wdata.busy = 1'b0;
				cnt_d = cnt_q + CB'(1);
				cur_d.len = req_q.request_size;
				cur_d.busy = 1'b1;
				res_d.status = ffsa_pkg::StOk;
				res_d.block_offset = cur_q.start;
				res_d.grant_size = req_q.request_size;
				state_d = ffsa_pkg::S_DEL_WR;
				j_d = cnt_q + CB'(1);
			end
			ffsa_pkg::S_REL_NEXT: begin
				if (!rd.busy) begin
					cur_d.len = cur_q.len + rd.len;
				end
				wen = 1'b1;
				wdata = cur_d;
				if (!rd.busy) begin
					// delete entry i+1 after the previous merge check
					j_d = i_q + CB'(1);
				end else begin
					j_d = '1;
				end
				state_d = ffsa_pkg::S_REL_PREV;
				raddr = IB'(i_q - CB'(1));
			end
			ffsa_pkg::S_REL_PREV: begin
				// rd holds entry i-1 when i > 0
				if (state_q == ffsa_pkg::S_REL_PREV && i_q != '0 && !rd.busy) begin
					wen = 1'b1;
					waddr = IB'(i_q - CB'(1));
					wdata = rd;
					wdata.len = rd.len + cur_q.len;
					// previous absorbs i; delete i (and i+1 if merged too)
					if (j_q == i_q + CB'(1)) begin
						j_d = i_q;
						cur_d.busy = 1'b1; // marks a double delete
					end else begin
						j_d = i_q;
						cur_d.busy = 1'b0;
					end
					state_d = ffsa_pkg::S_DEL_RD;
				end else if (j_q == i_q + CB'(1) && i_q + CB'(1) < cnt_q) begin
					cur_d.busy = 1'b0;
					state_d = ffsa_pkg::S_DEL_RD;
				end else begin
					state_d = ffsa_pkg::S_DONE;
				end
			end
			ffsa_pkg::S_DEL_RD: begin
				// move entry j+1 (or j+2 for a double delete) down to j
				if (j_q + (cur_q.busy ? CB'(2) : CB'(1)) >= cnt_q) begin
					cnt_d = cnt_q - (cur_q.busy ? CB'(2) : CB'(1));
					state_d = ffsa_pkg::S_DONE;
				end else begin
					raddr = IB'(j_q + (cur_q.busy ? CB'(2) : CB'(1)));
					state_d = ffsa_pkg::S_DEL_WR;
				end
			end
			ffsa_pkg::S_DEL_WR: begin
				if (j_q == cnt_q) begin
					// tail of a split: write the busy head
					wen = 1'b1;
					waddr = i_q[IB-1:0];
					wdata = cur_q;
					state_d = ffsa_pkg::S_DONE;
				end else begin
					wen = 1'b1;
					waddr = j_q[IB-1:0];
					wdata = rd;
					j_d = j_q + CB'(1);
					state_d = ffsa_pkg::S_DEL_RD;
				end
			end
			ffsa_pkg::S_DONE: begin
				done_d = 1'b1;
				state_d = ffsa_pkg::S_IDLE;
			end
			default: state_d = ffsa_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/first_fit_segment_allocator_core.sv */
`default_nettype none
// First-fit heap segment allocator. A start beat is taken when busy is low;
// one result beat follows on done, which the receiver must take that cycle
// since it cannot stall. The segment table lives in one memory with a single
// read port, so a request reads the entries that it scans one at a time, and a
// split that inserts or a release that merges moves entries one at a time.
// Writing heap_bytes reinitialises the table through a registered init strobe;
// no clearing pass.
module first_fit_segment_allocator_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic start,
	input wire ffsa_pkg::req_t req,
	output logic busy,
	output logic done,
	output ffsa_pkg::rsp_t result
);

	ffsa_pkg::cfg_t cfg;

	ffsa_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	ffsa_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

endmodule
`default_nettype wire

/* rtl/ffsa_checker.sv */
`default_nettype none
module ffsa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire ffsa_pkg::rsp_t result
);

	// an accepted beat makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// done is a single cycle pulse
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// failures report zero offset and size
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ffsa_pkg::StOk |->
		result.block_offset == '0 && result.grant_size == '0)
		else $error("failure payload not zero");

	// status codes stay in range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ffsa_pkg::StFull) else $error("bad status");

endmodule

bind first_fit_segment_allocator_core ffsa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.result(result)
);
`default_nettype wire

/* tb/first_fit_segment_allocator_core_chk.sv */
module first_fit_segment_allocator_core_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	input wire logic start,
	input wire logic busy,
	input wire ffsa_pkg::req_t req,
	input wire logic done,
	input wire ffsa_pkg::rsp_t result,
	output int fail_count,
	output int pending
);

	// shadow registers and segment table
	logic [23:0] heap_reg;
	logic win_en_reg;
	logic [23:0] win_lo_reg, win_hi_reg;
	logic [23:0] seg_start [ffsa_pkg::MaxSegments];
	logic [23:0] seg_len [ffsa_pkg::MaxSegments];
	logic seg_busy [ffsa_pkg::MaxSegments];
	int seg_cnt;
	ffsa_pkg::rsp_t grant_q [$];

	function automatic void table_clear();
		logic [23:0] sz;
		sz = (heap_reg == 24'd0) ? ffsa_pkg::DefaultHeap : heap_reg;
		for (int i = 0; i < ffsa_pkg::MaxSegments; i++) begin
			seg_start[i] = '0;
			seg_len[i] = '0;
			seg_busy[i] = 1'b0;
		end
		seg_len[0] = sz;
		seg_cnt = 1;
	endfunction

	function automatic void drop_seg(int k);
		for (int j = k; j < seg_cnt - 1; j++) begin
			seg_start[j] = seg_start[j+1];
			seg_len[j] = seg_len[j+1];
			seg_busy[j] = seg_busy[j+1];
		end
		seg_cnt--;
	endfunction

	// first-fit grant or release with merging
	function automatic ffsa_pkg::rsp_t predict_grant(ffsa_pkg::req_t r);
		ffsa_pkg::rsp_t o;
		logic [23:0] lo, hi;
		o = '0;
		o.status = ffsa_pkg::StNoFit;
		if (r.action == 1'b0) begin
			lo = (win_lo_reg > win_hi_reg) ? win_hi_reg : win_lo_reg;
			hi = (win_lo_reg > win_hi_reg) ? win_lo_reg : win_hi_reg;
			if (win_en_reg && (r.request_size < lo || r.request_size > hi)) begin
				o.status = ffsa_pkg::StWindow;
			end else if (r.request_size != 24'd0) begin
				for (int i = 0; i < seg_cnt; i++) begin
					if (!seg_busy[i] && seg_len[i] >= r.request_size) begin
						if (seg_len[i] != r.request_size) begin
							if (seg_cnt >= ffsa_pkg::MaxSegments) begin
								o.status = ffsa_pkg::StFull;
								return o;
							end
							for (int j = seg_cnt; j > i + 1; j--) begin
								seg_start[j] = seg_start[j-1];
								seg_len[j] = seg_len[j-1];
								seg_busy[j] = seg_busy[j-1];
							end
							seg_start[i+1] = seg_start[i] + r.request_size;
							seg_len[i+1] = seg_len[i] - r.request_size;
							seg_busy[i+1] = 1'b0;
							seg_cnt++;
							seg_len[i] = r.request_size;
						end
						seg_busy[i] = 1'b1;
						o.status = ffsa_pkg::StOk;
						o.block_offset = seg_start[i];
						o.grant_size = r.request_size;
						return o;
					end
				end
			end
		end else begin
			o.status = ffsa_pkg::StNotFound;
			for (int i = 0; i < seg_cnt; i++) begin
				if (seg_start[i] == r.release_offset) begin
					o.status = ffsa_pkg::StOk;
					o.block_offset = r.release_offset;
					o.grant_size = seg_len[i];
					seg_busy[i] = 1'b0;
					if (i + 1 < seg_cnt && !seg_busy[i+1]) begin
						seg_len[i] = seg_len[i] + seg_len[i+1];
						drop_seg(i + 1);
					end
					if (i > 0 && !seg_busy[i-1]) begin
						seg_len[i-1] = seg_len[i-1] + seg_len[i];
						drop_seg(i);
					end
					return o;
				end
			end
		end
		return o;
	endfunction

	// watch register writes, request beats and result beats
	always @(posedge clk or negedge arst_n) begin
		ffsa_pkg::rsp_t exp_r;
		if (!arst_n) begin
			heap_reg = ffsa_pkg::DefaultHeap;
			win_en_reg = 1'b0;
			win_lo_reg = ffsa_pkg::DefaultWindow;
			win_hi_reg = ffsa_pkg::DefaultWindow;
			table_clear();
			grant_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (grant_q.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $time, result);
					fail_count++;
				end else begin
					exp_r = grant_q.pop_front();
					if (result.status !== exp_r.status
						|| result.block_offset !== exp_r.block_offset
						|| result.grant_size !== exp_r.grant_size) begin
						$display("%0t: mismatch expected st=%0d off=%0d size=%0d %s%0d off=%0d size=%0d",
							$time, exp_r.status, exp_r.block_offset, exp_r.grant_size,
							"actual st=", result.status, result.block_offset,
							result.grant_size);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					ffsa_pkg::RegHeap: begin
						heap_reg = pwdata[23:0];
						table_clear();
					end
					ffsa_pkg::RegWinEn: win_en_reg = pwdata[0];
					ffsa_pkg::RegWinLo: win_lo_reg = pwdata[23:0];
					ffsa_pkg::RegWinHi: win_hi_reg = pwdata[23:0];
					default: ;
				endcase
			end
			if (start && !busy) grant_q.push_back(predict_grant(req));
			pending = grant_q.size();
		end
	end
endmodule

/* tb/first_fit_segment_allocator_core_tb.sv */
module first_fit_segment_allocator_core_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	ffsa_pkg::req_t req = '0;
	logic busy, done;
	ffsa_pkg::rsp_t result;
	int fail_count, pending;
	int cycle_count = 0;
	logic [23:0] live_offs [$];

	always #6 clk = ~clk;

	first_fit_segment_allocator_core uut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .req, .busy, .done, .result
	);

	first_fit_segment_allocator_core_chk chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.start, .busy, .req, .done, .result, .fail_count, .pending
	);

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one request beat; gap only when allowed
	task automatic send_beat(logic act, logic [23:0] sz, logic [23:0] off, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(posedge clk);
		req <= '{action: act, request_size: sz, release_offset: off};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b0;
		// wait for its result so the offset list stays current
		while (!done) @(posedge clk);
		if (act == 1'b0 && result.status == ffsa_pkg::StOk)
			live_offs.push_back(result.block_offset);
	endtask

	task automatic alloc(logic [23:0] sz, bit gaps);
		send_beat(1'b0, sz, 24'($urandom()), gaps);
	endtask

	task automatic free_at(logic [23:0] off, bit gaps);
		send_beat(1'b1, 24'($urandom()), off, gaps);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		live_offs.delete();
	endtask

	task automatic random_phase(int n, int max_sz, bit gaps);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k < 5) alloc(24'($urandom_range(1, max_sz)), gaps);
			else if (k < 8 && live_offs.size() != 0) begin
				k = $urandom_range(0, live_offs.size() - 1);
				free_at(live_offs[k], gaps);
				live_offs.delete(k);
			end else if (k == 8) free_at(24'($urandom()), gaps);
			else alloc(24'($urandom()), gaps);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// directed: defaults, zero request, exact fit, merges, misses
		alloc(24'd0, 0);
		alloc(24'hFFFFFF, 0);
		alloc(24'd1000, 0);
		alloc(24'd2000, 0);
		alloc(24'd3000, 0);
		free_at(24'd1000, 0);
		free_at(24'd1000, 0);
		free_at(24'd0, 0);
		free_at(24'd5555, 0);
		free_at(24'd3000, 0);
		alloc(24'd10000000, 0);
		free_at(24'd0, 0);
		drain();
		// small heap, window on, reversed limits
		reg_write(ffsa_pkg::RegHeap, 32'd100);
		reg_write(ffsa_pkg::RegWinEn, 32'd1);
		reg_write(ffsa_pkg::RegWinLo, 32'd40);
		reg_write(ffsa_pkg::RegWinHi, 32'd10);
		alloc(24'd9, 0);
		alloc(24'd41, 0);
		alloc(24'd10, 0);
		alloc(24'd40, 0);
		alloc(24'd40, 0);
		drain();
		// zero heap selects default; table fill to full
		reg_write(ffsa_pkg::RegWinEn, 32'd0);
		reg_write(ffsa_pkg::RegHeap, 32'd0);
		for (int i = 0; i < 66; i++) alloc(24'd1, 0);
		drain();
		reg_write(ffsa_pkg::RegHeap, 32'hFFFFFFFF);
		reg_write(ffsa_pkg::RegWinLo, 32'd0);
		reg_write(ffsa_pkg::RegWinHi, 32'hFFFFFF);
		reg_write(ffsa_pkg::RegWinEn, 32'd1);
		alloc(24'hFFFFFF, 0);
		alloc(24'd1, 0);
		drain();
		// random phases over several settings
		reg_write(ffsa_pkg::RegWinEn, 32'd0);
		reg_write(ffsa_pkg::RegHeap, 32'd4096);
		random_phase(400, 300, 1);
		drain();
		reg_write(ffsa_pkg::RegHeap, $urandom());
		reg_write(ffsa_pkg::RegWinEn, 32'd1);
		reg_write(ffsa_pkg::RegWinLo, $urandom_range(0, 2000));
		reg_write(ffsa_pkg::RegWinHi, $urandom_range(0, 200000));
		random_phase(400, 300000, 1);
		drain();
		reg_write(ffsa_pkg::RegWinEn, 32'd0);
		reg_write(ffsa_pkg::RegHeap, 32'd1000);
		random_phase(450, 40, 1);
		drain();
		reg_write(ffsa_pkg::RegHeap, 32'hFFFFFF);
		random_phase(300, 24'hFFFFFF, 0);
		drain();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
